@@ sv/fibonacci_growth_indexed_list_top_macros.svh @@
// Assertion helpers shared by the list block.
`ifndef FIBONACCI_GROWTH_INDEXED_LIST_TOP_MACROS_SVH
`define FIBONACCI_GROWTH_INDEXED_LIST_TOP_MACROS_SVH

// Same-cycle implication.
`define FGL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FGL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/fgl_pkg.sv @@
package fgl_pkg;

   localparam int POS_W = 7;
   localparam int DATA_W = 32;
   localparam int CNT_OUT_W = 7;

   // request actions
   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_LOOKUP = 3'd1;
   localparam logic [2:0] ACT_REMOVE = 3'd2;
   localparam logic [2:0] ACT_POP    = 3'd3;
   localparam logic [2:0] ACT_PUSH   = 3'd4;

   // response status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]              action;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] item_value;
   } fgl_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [1:0]               status;
      logic [CNT_OUT_W-1:0]     entry_count;
      logic [CNT_OUT_W-1:0]     logical_capacity;
   } fgl_rsp_type;

   // count/capacity update request from the sequencer
   typedef struct packed {
      logic inc;
      logic dec;
      logic pop_op;
   } fgl_size_cmd_type;

endpackage

@@ sv/fibonacci_growth_indexed_list_top.sv @@
// Sequence: a rejected request or spare action goes from idle straight to the done state,
//   lookup and pop pass the capture state, insert and push the shift state, and a remove
//   the capture and then the shift state; the done state waits for room in the output register.
// Throughput: one request at a time; one entry moved per cycle through the single read
//   and write port, req_ready returns with the result.
// Reset: synchronous, active high; count 0, capacity 1, no response pending, memory kept.
`include "fibonacci_growth_indexed_list_top_macros.svh"

module fibonacci_growth_indexed_list_top #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fgl_pkg::fgl_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fgl_pkg::fgl_rsp_type rsp_payload
);
   import fgl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = $clog2(2 * DEPTH + 1);
   localparam int MW = (CW > POS_W) ? CW : POS_W;

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CAPT  = 2'd1;  // read data lands, capture it
   localparam logic [1:0] S_SHIFT = 2'd2;  // move entries one per cycle
   localparam logic [1:0] S_DONE  = 2'd3;  // hand result to output register

   logic [1:0] state_ff, state_in;

   // latched request
   logic [2:0]          act_ff, act_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [1:0]          st_ff, st_in;
   logic [DATA_W-1:0]   rd_ff, rd_in;

   // shift engine
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [CW-1:0] rd_left_ff, rd_left_in;
   logic          pend_ff, pend_in;

   // output register
   fgl_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // entry memory, one write and one registered read per cycle
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic [AW-1:0]     mem_ra, mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic              mem_we;

   fgl_size_cmd_type size_cmd;
   logic [CW-1:0]    count;
   logic [KW-1:0]    capacity;

   logic          req_fire;
   logic [MW-1:0] pos_ext, cnt_ext;
   logic          shift_up;
   logic          shift_end;
   logic          shift_busy;   // write pending and more reads to issue
   logic          shift_last;

   fgl_sizer #(
      .CW    (CW),
      .KW    (KW)
   ) u_sizer (
      .clock    (clock),
      .reset    (reset),
      .cmd      (size_cmd),
      .count    (count),
      .capacity (capacity)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign pos_ext    = MW'(req_payload.position);
   assign cnt_ext    = MW'(count);
   assign shift_up   = act_ff inside {ACT_INSERT, ACT_PUSH};
   assign shift_end  = (rd_left_ff == CW'(0)) && !pend_ff;
   assign shift_busy = (state_ff == S_SHIFT) && pend_ff && (rd_left_ff != CW'(0));
   assign shift_last = (state_ff == S_SHIFT) && shift_end;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      st_in        = st_ff;
      rd_in        = rd_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      size_cmd     = '0;
      mem_ra       = rd_idx_ff;
      mem_wa       = wr_idx_ff;
      mem_wd       = rdata_ff;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // pop reads the last entry, everything else the requested index
            if (req_payload.action == ACT_POP) begin
               mem_ra = AW'(count - CW'(1));
            end else begin
               mem_ra = AW'(req_payload.position);
            end
            if (req_fire) begin
               act_in  = req_payload.action;
               pos_in  = AW'(req_payload.position);
               val_in  = $unsigned(req_payload.item_value);
               st_in   = ST_OK;
               rd_in   = '0;
               pend_in = 1'b0;
               state_in = S_DONE;
               case (req_payload.action)
                  ACT_INSERT, ACT_PUSH: begin
                     if (req_payload.action == ACT_INSERT && pos_ext > cnt_ext) begin
                        st_in = ST_RANGE;
                     end else if (count == CW'(DEPTH)) begin
                        st_in = ST_FULL;
                     end else begin
                        // push is an insert at the current count
                        if (req_payload.action == ACT_PUSH) begin
                           pos_in     = AW'(count);
                           rd_left_in = '0;
                        end else begin
                           rd_left_in = count - CW'(req_payload.position);
                        end
                        rd_idx_in    = AW'(count - CW'(1));
                        size_cmd.inc = 1'b1;
                        state_in     = S_SHIFT;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (pos_ext >= cnt_ext) begin
                        st_in = ST_RANGE;
                     end else begin
                        state_in = S_CAPT;
                     end
                  end
                  ACT_REMOVE: begin
                     if (pos_ext >= cnt_ext) begin
                        st_in = ST_RANGE;
                     end else begin
                        rd_idx_in    = AW'(req_payload.position) + AW'(1);
                        rd_left_in   = count - CW'(1) - CW'(req_payload.position);
                        size_cmd.dec = 1'b1;
                        state_in     = S_CAPT;
                     end
                  end
                  ACT_POP: begin
                     if (count == CW'(0)) begin
                        st_in = ST_UNDER;
                     end else begin
                        size_cmd.dec    = 1'b1;
                        size_cmd.pop_op = 1'b1;
                        state_in        = S_CAPT;
                     end
                  end
                  default: begin
                     // unused action: no change, status ok
                  end
               endcase
            end
         end
         S_CAPT: begin
            rd_in = rdata_ff;
            if (act_ff == ACT_REMOVE) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            // write back what was read last cycle, issue the next read
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (rd_left_ff != CW'(0)) begin
               pend_in    = 1'b1;
               rd_left_in = rd_left_ff - CW'(1);
               if (shift_up) begin
                  wr_idx_in = rd_idx_ff + AW'(1);
                  rd_idx_in = rd_idx_ff - AW'(1);
               end else begin
                  wr_idx_in = rd_idx_ff - AW'(1);
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
            end
            if (shift_end) begin
               // hole is open at the insert index
               if (shift_up) begin
                  mem_we = 1'b1;
                  mem_wa = pos_ff;
                  mem_wd = val_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.read_value       = $signed(rd_ff);
               rsp_in.status           = st_ff;
               rsp_in.entry_count      = CNT_OUT_W'(count);
               rsp_in.logical_capacity = CNT_OUT_W'(capacity);
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rd_left_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         rd_left_ff   <= rd_left_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      st_ff     <= st_in;
      rd_ff     <= rd_in;
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FGL_ASSERT_NXT(a_fire_leaves_idle, clock, reset, req_fire, !req_ready, "stuck in idle")
   `FGL_ASSERT_NOW(a_no_overlap, clock, reset, shift_busy, wr_idx_ff != rd_idx_ff, "overlap")
   `FGL_ASSERT_NXT(a_shift_finishes, clock, reset, shift_last, state_ff == S_DONE, "shift stuck")

endmodule

@@ sv/fgl_sizer.sv @@
`include "fibonacci_growth_indexed_list_top_macros.svh"

module fgl_sizer #(
   parameter int CW = 7,
   parameter int KW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fgl_pkg::fgl_size_cmd_type cmd,
   output logic [CW-1:0]             count,
   output logic [KW-1:0]             capacity
);
   import fgl_pkg::*;

   localparam int XW = KW + 1;

   logic [CW-1:0] count_ff, count_in, count_dn, count_up;
   logic [KW-1:0] cap_ff, cap_in;
   logic [KW-1:0] below_ff, below_in;
   logic          cap_ok;

   assign count_up = count_ff + CW'(1);
   assign cap_ok   = XW'(cap_ff) >= XW'(count_ff);

   always_comb begin
      count_in = count_ff;
      cap_in   = cap_ff;
      below_in = below_ff;
      count_dn = count_ff - CW'(1);
      if (cmd.inc) begin
         count_in = count_up;
         if (XW'(count_ff) + XW'(1) > XW'(cap_ff)) begin
            // next Fibonacci step; 1 -> 2 is the odd one
            if (cap_ff == KW'(1)) begin
               cap_in   = KW'(2);
               below_in = KW'(1);
            end else begin
               cap_in   = cap_ff + below_ff;
               below_in = cap_ff;
            end
         end
      end else if (cmd.dec) begin
         count_in = count_dn;
         if (cmd.pop_op && count_dn == CW'(0) && cap_ff == KW'(2)) begin
            cap_in   = KW'(1);
            below_in = KW'(0);
         end else if (cap_ff > KW'(2) && XW'(count_dn) < XW'(cap_ff - below_ff)) begin
            // two steps below capacity is cap - below
            cap_in   = below_ff;
            below_in = cap_ff - below_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= KW'(1);
         below_ff <= '0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
         below_ff <= below_in;
      end
   end

   assign count    = count_ff;
   assign capacity = cap_ff;

   `FGL_ASSERT_NOW(a_cap_covers_count, clock, reset, 1'b1, cap_ok, "capacity below count")
   `FGL_ASSERT_NOW(a_below_lt_cap, clock, reset, 1'b1, below_ff < cap_ff, "bad below step")
   `FGL_ASSERT_NXT(a_inc_step, clock, reset, cmd.inc, count_ff == $past(count_up), "count stuck")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import fgl_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int MAX_POS    = 127;      // every bit of the 7-bit position field

   // action codes the block does not decode: they answer ok and change nothing
   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   // stimulus biasing for the random blocks
   localparam int MODE_GROW   = 0;
   localparam int MODE_MIXED  = 1;
   localparam int MODE_SHRINK = 2;
   localparam int MODE_READ   = 3;

   localparam int RANDOM_BLOCKS = 8;
   localparam int BLOCK_ITEMS   = 100;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the list, count and Fibonacci capacity,
   // works out the response for each accepted request and checks responses
   // in order against the queue of predicted ones.
   // -------------------------------------------------------------------------
   class list_scoreboard;
      logic signed [DATA_W-1:0] words [LIST_DEPTH];
      int unsigned count;
      int unsigned cap;
      int unsigned cap_below;
      fgl_rsp_type predicted [$];
      int errors;

      function new();
         count     = 0;
         cap       = 1;
         cap_below = 0;
         errors    = 0;
      endfunction

      // Fibonacci number one step below the smallest Fibonacci number >= n
      function int unsigned fib_step_down(int unsigned n);
         int unsigned a;
         int unsigned b;
         int unsigned c;
         a = 0;
         b = 1;
         while (b < n) begin
            c = a + b;
            a = b;
            b = c;
         end
         return a;
      endfunction

      // smallest Fibonacci number >= n
      function int unsigned fib_ceiling(int unsigned n);
         int unsigned a;
         int unsigned b;
         int unsigned c;
         a = 0;
         b = 1;
         while (b < n) begin
            c = a + b;
            a = b;
            b = c;
         end
         return b;
      endfunction

      function void set_capacity(int unsigned c);
         cap       = c;
         cap_below = fib_step_down(c);
      endfunction

      function void shrink_if_sparse();
         int unsigned two_below;
         two_below = fib_step_down(cap_below);
         if (two_below >= 1 && count < two_below)
            set_capacity(cap_below);
      endfunction

      function logic [1:0] insert_word(int unsigned pos, logic signed [DATA_W-1:0] val);
         int unsigned i;
         if (pos > count)
            return ST_RANGE;
         if (count >= LIST_DEPTH)
            return ST_FULL;
         if (count + 1 > cap)
            set_capacity(fib_ceiling(cap + 1));
         for (i = count; i > pos; i--)
            words[i] = words[i-1];
         words[pos] = val;
         count++;
         return ST_OK;
      endfunction

      function void note_request(fgl_req_type req);
         fgl_rsp_type rsp;
         int unsigned pos;
         int unsigned i;
         pos = req.position;
         rsp.read_value = '0;
         rsp.status     = ST_OK;
         case (req.action)
            ACT_INSERT: rsp.status = insert_word(pos, req.item_value);
            ACT_PUSH:   rsp.status = insert_word(count, req.item_value);
            ACT_LOOKUP: begin
               if (pos >= count)
                  rsp.status = ST_RANGE;
               else
                  rsp.read_value = words[pos];
            end
            ACT_REMOVE: begin
               if (pos >= count) begin
                  rsp.status = ST_RANGE;
               end else begin
                  rsp.read_value = words[pos];
                  for (i = pos; i + 1 < count; i++)
                     words[i] = words[i+1];
                  count--;
                  shrink_if_sparse();
               end
            end
            ACT_POP: begin
               if (count == 0) begin
                  rsp.status = ST_UNDER;
               end else begin
                  rsp.read_value = words[count-1];
                  count--;
                  if (count == 0 && cap == 2)
                     set_capacity(1);
                  else
                     shrink_if_sparse();
               end
            end
            default: ;
         endcase
         rsp.entry_count      = count[CNT_OUT_W-1:0];
         rsp.logical_capacity = cap[CNT_OUT_W-1:0];
         predicted.push_back(rsp);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH %s", $realtime, msg);
         errors++;
      endtask

      task check_response(fgl_rsp_type got);
         fgl_rsp_type want;
         if (predicted.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", got));
         end else begin
            want = predicted.pop_front();
            if (got.read_value !== want.read_value)
               report_mismatch($sformatf("read_value got %h want %h",
                                         got.read_value, want.read_value));
            if (got.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         got.status, want.status));
            if (got.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         got.entry_count, want.entry_count));
            if (got.logical_capacity !== want.logical_capacity)
               report_mismatch($sformatf("logical_capacity got %0d want %0d",
                                         got.logical_capacity, want.logical_capacity));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   fgl_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   fgl_rsp_type rsp_payload;

   list_scoreboard sb = new();

   // when clear, neither side idles (back-to-back stretches)
   bit idle_on;
   int stall_left;

   fibonacci_growth_indexed_list_top #(.DEPTH(LIST_DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // known values on every input before the first edge
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      idle_on     = 1'b1;
      stall_left  = 0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side: ready drops for random stretches. One NBA per edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 99) < 25)
            stall_left <= pick_gap();
      end
   end

   // Response monitor: every accepted response transaction is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_payload);
   end

   // Drive one request transaction. Valid is lowered only when a gap follows,
   // so back-to-back items keep valid high without a drop in the same step.
   task automatic issue(input logic [2:0] act, input int unsigned pos,
                        input logic [DATA_W-1:0] val);
      fgl_req_type req;
      int gap;
      req.action     = act;
      req.position   = pos[POS_W-1:0];
      req.item_value = val;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(req);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      case (r)
         0, 1:    return 32'h7fff_ffff;
         2, 3:    return 32'h8000_0000;
         4:       return '0;
         5:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly a position near the live range, sometimes anywhere in the field
   function automatic int unsigned pick_pos();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(0, sb.count);
      return $urandom_range(0, MAX_POS);
   endfunction

   function automatic logic [2:0] pick_action(input int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            if (r < 40) return ACT_PUSH;
            if (r < 80) return ACT_INSERT;
            if (r < 88) return ACT_LOOKUP;
            if (r < 94) return ACT_REMOVE;
            if (r < 98) return ACT_POP;
         end
         MODE_SHRINK: begin
            if (r < 40) return ACT_POP;
            if (r < 80) return ACT_REMOVE;
            if (r < 90) return ACT_LOOKUP;
            if (r < 94) return ACT_PUSH;
            if (r < 98) return ACT_INSERT;
         end
         MODE_READ: begin
            if (r < 60) return ACT_LOOKUP;
            if (r < 70) return ACT_PUSH;
            if (r < 80) return ACT_INSERT;
            if (r < 88) return ACT_REMOVE;
            if (r < 96) return ACT_POP;
         end
         default: begin
            if (r < 20) return ACT_PUSH;
            if (r < 40) return ACT_INSERT;
            if (r < 60) return ACT_LOOKUP;
            if (r < 78) return ACT_REMOVE;
            if (r < 96) return ACT_POP;
         end
      endcase
      // the rest lands on the spare codes
      case ($urandom_range(0, 2))
         0:       return ACT_SPARE_5;
         1:       return ACT_SPARE_6;
         default: return ACT_SPARE_7;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int blk;
      int n;
      int mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-list errors first
      issue(ACT_POP,    0, pick_value());          // underflow on empty
      issue(ACT_LOOKUP, 0, pick_value());          // lookup past end
      issue(ACT_REMOVE, 0, pick_value());          // remove past end
      issue(ACT_INSERT, 1, pick_value());          // insert past end
      issue(ACT_PUSH,   0, 32'h7fff_ffff);
      issue(ACT_POP,    0, '0);                    // back to empty, capacity 1
      issue(ACT_PUSH,   0, 32'h8000_0000);
      issue(ACT_PUSH,   0, '0);                    // capacity grows to 2
      issue(ACT_POP,    0, '0);
      issue(ACT_POP,    0, '0);                    // count 0 at capacity 2 -> 1
      // build a few entries, growing through 2, 3, 5
      issue(ACT_INSERT, 0, '1);
      issue(ACT_INSERT, 0, 32'd123);
      issue(ACT_INSERT, 1, 32'h5555_5555);         // middle insert shifts tail
      issue(ACT_PUSH,   0, 32'haaaa_aaaa);
      issue(ACT_INSERT, 4, 32'h7fff_ffff);         // insert at end
      issue(ACT_LOOKUP, MAX_POS, '0);              // all position bits set
      issue(ACT_INSERT, MAX_POS, '1);
      issue(ACT_REMOVE, MAX_POS, '0);
      issue(ACT_LOOKUP, 0, '0);
      issue(ACT_LOOKUP, 4, '0);
      issue(ACT_REMOVE, 1, '0);                    // middle remove shifts tail
      issue(ACT_SPARE_5, MAX_POS, '1);
      issue(ACT_SPARE_6, 0, '0);
      issue(ACT_SPARE_7, 3, 32'h8000_0000);
      issue(ACT_REMOVE, 0, '0);
      issue(ACT_POP,    0, '0);                    // count 2, capacity stays 5

      // random blocks: grow fills the store and hits full, shrink drains it
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         case (blk % 4)
            0:       mode = MODE_GROW;
            1:       mode = MODE_MIXED;
            2:       mode = MODE_SHRINK;
            default: mode = MODE_READ;
         endcase
         idle_on = (blk % 3 != 2);
         for (n = 0; n < BLOCK_ITEMS; n++)
            issue(pick_action(mode), pick_pos(), pick_value());
      end

      req_valid <= 1'b0;
      idle_on = 1'b1;

      // drain outstanding responses, then let the block settle
      while (sb.predicted.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);

      if (sb.errors == 0)
         $display("fibonacci_growth_indexed_list_top verification clean");
      else
         $display("fibonacci_growth_indexed_list_top verification failed");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("fibonacci_growth_indexed_list_top verification failed");
      $finish;
   end

endmodule
